### rtl/dht_pkg.sv
// Shared types and constants for the double-hashing key/value table.
// Used by the controller, the datapath, the top level and the port checker.
// Depends on nothing.
package dht_pkg;

  // Fixed field widths of the request and result channels.
  localparam int KEY_W    = 32;
  localparam int VALUE_W  = 32;
  localparam int KIND_W   = 2;
  localparam int STATUS_W = 3;
  localparam int SLOT_W   = 5;

  // Default geometry of the table.
  localparam int DEF_TABLE_SIZE   = 31;
  localparam int DEF_SECOND_PRIME = 7;

  // Key bits folded into the hash remainders per cycle.
  localparam int HASH_BITS = 8;

  // Operation codes of a request.
  localparam logic [KIND_W-1:0] KIND_INSERT = 2'd0;
  localparam logic [KIND_W-1:0] KIND_REMOVE = 2'd1;
  localparam logic [KIND_W-1:0] KIND_SEARCH = 2'd2;

  // Result status codes.
  localparam logic [STATUS_W-1:0] ST_INSERTED    = 3'd0;
  localparam logic [STATUS_W-1:0] ST_OVERWRITTEN = 3'd1;
  localparam logic [STATUS_W-1:0] ST_DELETED     = 3'd2;
  localparam logic [STATUS_W-1:0] ST_FOUND       = 3'd3;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND   = 3'd4;
  localparam logic [STATUS_W-1:0] ST_FULL        = 3'd5;

  // Slot marks.
  localparam logic [1:0] MARK_EMPTY   = 2'd0;
  localparam logic [1:0] MARK_USED    = 2'd1;
  localparam logic [1:0] MARK_DELETED = 2'd2;

  // Controller states.
  typedef enum logic [2:0] {
    S_IDLE,
    S_HASH,
    S_STEP,
    S_READ,
    S_CHECK,
    S_UPDATE,
    S_EMIT
  } dht_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic hash;
    logic calc_step;
    logic read;
    logic check;
    logic update;
    logic emit;
  } dht_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic hash_done;
    logic skip;
    logic stop;
  } dht_stat_t;

endpackage

### rtl/double_hash_table_core.sv
// Top level of the double-hashing key/value table.
// Joins dht_ctrl and dht_datapath and holds the result output register; uses dht_pkg.
//
// Open-addressing table of TABLE_SIZE slots with double hashing: probe j of a
// key visits slot (key mod TABLE_SIZE + j * step) mod TABLE_SIZE, where step is
// (SECOND_PRIME - key mod SECOND_PRIME) reduced modulo TABLE_SIZE. Each
// request (insert, remove or search) yields exactly one result. Requests are
// handled one at a time, each probing up to TABLE_SIZE slots; removes and
// searches on an empty table and unknown kinds skip probing. After acceptance
// the 32-bit key is folded into both hash remainders a byte at a time, then
// the step is computed, and each probe does the registered read of the key
// memory, value memory and slot mark and then the compare. The table and the
// result are then written, and the result moves into the output register
// once that register is free. The output register lets the next request be
// accepted while a result is still waiting to be taken. Reset marks every
// slot empty at once.
module double_hash_table_core import dht_pkg::*; #(
  parameter int TABLE_SIZE   = DEF_TABLE_SIZE,
  parameter int SECOND_PRIME = DEF_SECOND_PRIME
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       req_valid,
  output logic                       req_stall,
  input  logic [KIND_W-1:0]          kind,
  input  logic [KEY_W-1:0]           key,
  input  logic signed [VALUE_W-1:0]  value,
  output logic                       res_valid,
  input  logic                       res_stall,
  output logic [STATUS_W-1:0]        status,
  output logic [SLOT_W-1:0]          slot,
  output logic signed [VALUE_W-1:0]  found_value
);

  dht_cmd_t                  cmd;
  dht_stat_t                 stat;
  logic                      out_free;
  logic [STATUS_W-1:0]       result_status;
  logic [SLOT_W-1:0]         result_slot;
  logic signed [VALUE_W-1:0] result_found_value;

  // The output register can take a new result when empty or being drained.
  assign out_free = !res_valid || !res_stall;

  dht_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .out_free  (out_free),
    .stat      (stat),
    .req_stall (req_stall),
    .cmd       (cmd)
  );

  dht_datapath #(
    .TABLE_SIZE   (TABLE_SIZE),
    .SECOND_PRIME (SECOND_PRIME)
  ) u_datapath (
    .clk                (clk),
    .rst                (rst),
    .cmd                (cmd),
    .stat               (stat),
    .kind               (kind),
    .key                (key),
    .value              (value),
    .result_status      (result_status),
    .result_slot        (result_slot),
    .result_found_value (result_found_value)
  );

  // Result valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (cmd.emit) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  // Result payload.
  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      status      <= result_status;
      slot        <= result_slot;
      found_value <= result_found_value;
    end
  end

endmodule

### rtl/dht_ctrl.sv
// Controller state machine of the double-hashing table.
// Sequences hashing, probing and the table update; depends on dht_pkg.
module dht_ctrl import dht_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      req_valid,
  input  logic      out_free,
  input  dht_stat_t stat,
  output logic      req_stall,
  output dht_cmd_t  cmd
);

  dht_state_t state;
  dht_state_t state_next;

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next-state logic.
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (req_valid) state_next = S_HASH;
      end
      S_HASH: begin
        if (stat.hash_done) state_next = S_STEP;
      end
      S_STEP: begin
        state_next = stat.skip ? S_UPDATE : S_READ;
      end
      S_READ: begin
        state_next = S_CHECK;
      end
      S_CHECK: begin
        state_next = stat.stop ? S_UPDATE : S_READ;
      end
      S_UPDATE: begin
        state_next = S_EMIT;
      end
      S_EMIT: begin
        if (out_free) state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Output decode: one command per state.
  always_comb begin
    cmd       = '0;
    req_stall = 1'b1;
    unique case (state)
      S_IDLE: begin
        req_stall = 1'b0;
        cmd.load  = req_valid;
      end
      S_HASH:   cmd.hash      = 1'b1;
      S_STEP:   cmd.calc_step = 1'b1;
      S_READ:   cmd.read      = 1'b1;
      S_CHECK:  cmd.check     = 1'b1;
      S_UPDATE: cmd.update    = 1'b1;
      S_EMIT:   cmd.emit      = out_free;
      default: begin
        req_stall = 1'b1;
      end
    endcase
  end

endmodule

### rtl/dht_datapath.sv
// Datapath of the double-hashing table: hash remainders, probe walker,
// key and value memories, slot marks, entry count and result registers.
// Depends on dht_pkg.
module dht_datapath import dht_pkg::*; #(
  parameter int TABLE_SIZE   = DEF_TABLE_SIZE,
  parameter int SECOND_PRIME = DEF_SECOND_PRIME
) (
  input  logic                       clk,
  input  logic                       rst,
  input  dht_cmd_t                   cmd,
  output dht_stat_t                  stat,
  input  logic [KIND_W-1:0]          kind,
  input  logic [KEY_W-1:0]           key,
  input  logic signed [VALUE_W-1:0]  value,
  output logic [STATUS_W-1:0]        result_status,
  output logic [SLOT_W-1:0]          result_slot,
  output logic signed [VALUE_W-1:0]  result_found_value
);

  localparam int IDX_W       = $clog2(TABLE_SIZE);
  localparam int CNT_W       = $clog2(TABLE_SIZE + 1);
  localparam int R2_W        = $clog2(SECOND_PRIME);
  localparam int SP_W        = $clog2(SECOND_PRIME + 1);
  localparam int HASH_CYCLES = KEY_W / HASH_BITS;
  localparam int HC_W        = $clog2(HASH_CYCLES);

  localparam logic [IDX_W:0]   TS_EXT   = (IDX_W + 1)'(TABLE_SIZE);
  localparam logic [R2_W:0]    SP_EXT   = (R2_W + 1)'(SECOND_PRIME);
  localparam logic [SP_W-1:0]  SP_VAL   = SP_W'(SECOND_PRIME);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(TABLE_SIZE - 1);
  localparam logic [HC_W-1:0]  HC_LAST  = HC_W'(HASH_CYCLES - 1);

  // Request registers.
  logic [KIND_W-1:0]  kind_reg;
  logic [KEY_W-1:0]   key_reg;
  logic [VALUE_W-1:0] value_reg;

  // Hash state.
  logic [KEY_W-1:0] key_shift;
  logic [IDX_W-1:0] rem1;
  logic [IDX_W-1:0] rem1_next;
  logic [R2_W-1:0]  rem2;
  logic [R2_W-1:0]  rem2_next;
  logic [HC_W-1:0]  hash_cnt;
  logic [IDX_W:0]   acc1;
  logic [R2_W:0]    acc2;
  logic [IDX_W:0]   acc3;
  logic [SP_W-1:0]  h2;
  logic [IDX_W-1:0] step_next;

  // Probe state.
  logic [IDX_W-1:0] pos;
  logic [IDX_W-1:0] step;
  logic [IDX_W:0]   pos_sum;
  logic [IDX_W-1:0] pos_adv;
  logic [CNT_W-1:0] probe_cnt;
  logic             hit;
  logic             ff_valid;
  logic [IDX_W-1:0] ff;

  // Table storage.
  logic [KEY_W-1:0]   key_mem [TABLE_SIZE];
  logic [VALUE_W-1:0] val_mem [TABLE_SIZE];
  logic [1:0]         mark    [TABLE_SIZE];
  logic [KEY_W-1:0]   key_rd;
  logic [VALUE_W-1:0] val_rd;
  logic [1:0]         mark_rd;
  logic [CNT_W-1:0]   entry_count;

  // Probe evaluation.
  logic probe_match;
  logic probe_empty;
  logic probe_deleted;
  logic probe_last;

  // Update decode.
  logic               key_we;
  logic               val_we;
  logic               mark_we;
  logic [1:0]         mark_wdata;
  logic [IDX_W-1:0]   wr_addr;
  logic               cnt_inc;
  logic               cnt_dec;
  logic [STATUS_W-1:0] status_next;
  logic [IDX_W-1:0]   slot_next;
  logic [VALUE_W-1:0] fv_next;

  // Fold one byte of the key into both remainders, most significant bit first.
  always_comb begin
    acc1 = {1'b0, rem1};
    acc2 = {1'b0, rem2};
    for (int i = 0; i < HASH_BITS; i++) begin
      acc1 = {acc1[IDX_W-1:0], key_shift[KEY_W-1-i]};
      if (acc1 >= TS_EXT) acc1 = acc1 - TS_EXT;
      acc2 = {acc2[R2_W-1:0], key_shift[KEY_W-1-i]};
      if (acc2 >= SP_EXT) acc2 = acc2 - SP_EXT;
    end
    rem1_next = acc1[IDX_W-1:0];
    rem2_next = acc2[R2_W-1:0];
  end

  // Second hash, reduced modulo the table size bit by bit.
  always_comb begin
    h2   = SP_VAL - SP_W'(rem2);
    acc3 = '0;
    for (int i = SP_W - 1; i >= 0; i--) begin
      acc3 = {acc3[IDX_W-1:0], h2[i]};
      if (acc3 >= TS_EXT) acc3 = acc3 - TS_EXT;
    end
    step_next = acc3[IDX_W-1:0];
  end

  // Next slot on the probe path.
  always_comb begin
    pos_sum = {1'b0, pos} + {1'b0, step};
    if (pos_sum >= TS_EXT) pos_sum = pos_sum - TS_EXT;
    pos_adv = pos_sum[IDX_W-1:0];
  end

  // Classify the slot just read.
  assign probe_empty   = (mark_rd == MARK_EMPTY);
  assign probe_deleted = (mark_rd == MARK_DELETED);
  assign probe_match   = (mark_rd == MARK_USED) && (key_rd == key_reg);
  assign probe_last    = (probe_cnt == CNT_LAST);

  // Status toward the controller.
  always_comb begin
    stat.hash_done = (hash_cnt == HC_LAST);
    stat.stop      = probe_match || probe_empty || probe_last;
    stat.skip      = (kind_reg != KIND_INSERT && kind_reg != KIND_REMOVE &&
                      kind_reg != KIND_SEARCH) ||
                     (kind_reg != KIND_INSERT && entry_count == '0);
  end

  // Request capture and hashing.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      kind_reg  <= kind;
      key_reg   <= key;
      value_reg <= value;
      key_shift <= key;
      rem1      <= '0;
      rem2      <= '0;
    end else if (cmd.hash) begin
      key_shift <= key_shift << HASH_BITS;
      rem1      <= rem1_next;
      rem2      <= rem2_next;
    end
  end

  // Hash cycle counter.
  always_ff @(posedge clk) begin
    if (rst) begin
      hash_cnt <= '0;
    end else if (cmd.load) begin
      hash_cnt <= '0;
    end else if (cmd.hash) begin
      hash_cnt <= hash_cnt + 1'b1;
    end
  end

  // Probe walker: start slot, step, probe count, hit and first free slot.
  always_ff @(posedge clk) begin
    if (rst) begin
      probe_cnt <= '0;
      hit       <= 1'b0;
      ff_valid  <= 1'b0;
    end else if (cmd.load) begin
      probe_cnt <= '0;
      hit       <= 1'b0;
      ff_valid  <= 1'b0;
    end else if (cmd.calc_step) begin
      pos  <= rem1;
      step <= step_next;
    end else if (cmd.check) begin
      probe_cnt <= probe_cnt + 1'b1;
      if (probe_match) hit <= 1'b1;
      if ((probe_empty || probe_deleted) && !ff_valid) begin
        ff_valid <= 1'b1;
        ff       <= pos;
      end
      if (!(probe_match || probe_empty)) pos <= pos_adv;
    end
  end

  // Decide the table update and the result.
  always_comb begin
    key_we      = 1'b0;
    val_we      = 1'b0;
    mark_we     = 1'b0;
    mark_wdata  = MARK_USED;
    wr_addr     = hit ? pos : ff;
    cnt_inc     = 1'b0;
    cnt_dec     = 1'b0;
    status_next = ST_NOT_FOUND;
    slot_next   = '0;
    fv_next     = '0;
    case (kind_reg)
      KIND_INSERT: begin
        if (hit) begin
          val_we      = 1'b1;
          status_next = ST_OVERWRITTEN;
          slot_next   = pos;
        end else if (ff_valid) begin
          key_we      = 1'b1;
          val_we      = 1'b1;
          mark_we     = 1'b1;
          cnt_inc     = 1'b1;
          status_next = ST_INSERTED;
          slot_next   = ff;
        end else begin
          status_next = ST_FULL;
        end
      end
      KIND_REMOVE: begin
        if (hit) begin
          mark_we     = 1'b1;
          mark_wdata  = MARK_DELETED;
          cnt_dec     = 1'b1;
          status_next = ST_DELETED;
          slot_next   = pos;
        end
      end
      KIND_SEARCH: begin
        if (hit) begin
          status_next = ST_FOUND;
          slot_next   = pos;
          fv_next     = val_rd;
        end
      end
      default: begin
        status_next = ST_NOT_FOUND;
      end
    endcase
  end

  // Key memory: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (cmd.update && key_we) key_mem[wr_addr] <= key_reg;
    if (cmd.read) key_rd <= key_mem[pos];
  end

  // Value memory: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (cmd.update && val_we) val_mem[wr_addr] <= value_reg;
    if (cmd.read) val_rd <= val_mem[pos];
  end

  // Slot marks live in flops so that reset empties the whole table at once.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < TABLE_SIZE; i++) mark[i] <= MARK_EMPTY;
    end else if (cmd.update && mark_we) begin
      mark[wr_addr] <= mark_wdata;
    end
  end

  // Registered mark read for the slot being probed.
  always_ff @(posedge clk) begin
    if (cmd.read) mark_rd <= mark[pos];
  end

  // Number of occupied slots; an empty table lets removes and searches skip probing.
  always_ff @(posedge clk) begin
    if (rst) begin
      entry_count <= '0;
    end else if (cmd.update) begin
      if (cnt_inc) begin
        entry_count <= entry_count + 1'b1;
      end else if (cnt_dec) begin
        entry_count <= entry_count - 1'b1;
      end
    end
  end

  // Result registers.
  always_ff @(posedge clk) begin
    if (cmd.update) begin
      result_status      <= status_next;
      result_slot        <= SLOT_W'(slot_next);
      result_found_value <= $signed(fv_next);
    end
  end

endmodule

### rtl/dht_checker.sv
// Port-level checker for the double-hashing table, bound to the top level.
// Depends on dht_pkg and double_hash_table_core.
module dht_checker import dht_pkg::*; (
  input logic                      clk,
  input logic                      rst,
  input logic                      req_valid,
  input logic                      req_stall,
  input logic                      res_valid,
  input logic                      res_stall,
  input logic [STATUS_W-1:0]       status,
  input logic [SLOT_W-1:0]         slot,
  input logic signed [VALUE_W-1:0] found_value
);

  // Requests are taken one at a time, so an accepted request closes the input.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    req_valid && !req_stall |=> req_stall)
    else $error("request accepted while the previous one was in progress");

  // Only defined status codes are reported.
  a_status_code: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> status <= ST_FULL)
    else $error("undefined status code");

  // A value is returned only on a search hit.
  a_value_on_hit: assert property (@(posedge clk) disable iff (rst)
    res_valid && status != ST_FOUND |-> found_value == '0)
    else $error("found_value nonzero without a search hit");

  // No slot is reported when nothing was touched.
  a_slot_on_miss: assert property (@(posedge clk) disable iff (rst)
    res_valid && (status == ST_NOT_FOUND || status == ST_FULL) |-> slot == '0)
    else $error("slot nonzero on not found or table full");

  // A stalled result holds.
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_stall |=> res_valid && $stable(status) && $stable(slot) &&
                                $stable(found_value))
    else $error("stalled result changed");

endmodule

bind double_hash_table_core dht_checker u_dht_checker (.*);

### bench/tb_double_hash_table_core.sv
// Testbench for double_hash_table_core: a directed table, then random requests in idling phases.
// Every result is checked against its directed expectation or an in-bench model of the double-hashing table.
// Depends on dht_pkg and the double_hash_table_core RTL.
module tb_double_hash_table_core import dht_pkg::*; ;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int TBL_SIZE    = DEF_TABLE_SIZE;
  localparam int SEC_PRIME   = DEF_SECOND_PRIME;
  localparam int LONG_HOLD   = 300;
  localparam int WDOG_LIMIT  = 20000;
  localparam int TAIL_CYCLES = 80;
  localparam int PHASES      = 8;
  localparam int PHASE_ITEMS = 125;

  // Kind code that the block treats as a no-op.
  localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

  typedef struct {
    logic [KIND_W-1:0]         kind;
    logic [KEY_W-1:0]          key;
    logic signed [VALUE_W-1:0] value;
  } req_t;

  typedef struct {
    logic [STATUS_W-1:0]       status;
    logic [SLOT_W-1:0]         slot;
    logic signed [VALUE_W-1:0] found_value;
  } res_t;

  typedef struct {
    req_t req;
    bit   typed;
    res_t want;
  } dir_row_t;

  logic                       clk;
  logic                       rst = 1'b1;
  logic                       req_valid = 1'b0;
  logic                       req_stall;
  logic [KIND_W-1:0]          kind = '0;
  logic [KEY_W-1:0]           key = '0;
  logic signed [VALUE_W-1:0]  value = '0;
  logic                       res_valid;
  logic                       res_stall = 1'b0;
  logic [STATUS_W-1:0]        status;
  logic [SLOT_W-1:0]          slot;
  logic signed [VALUE_W-1:0]  found_value;

  // Shadow copy of the table contents.
  logic [KEY_W-1:0]           shadow_key [TBL_SIZE];
  logic signed [VALUE_W-1:0]  shadow_val [TBL_SIZE];
  logic [1:0]                 shadow_mark [TBL_SIZE];

  res_t      results_due[$];
  dir_row_t  dir_rows[$];
  logic [KEY_W-1:0] key_pool [64];
  int        pool_n = 1;
  int        send_idle_pct = 0;
  int        recv_stall_pct = 0;
  int        holds_asked = 0;
  int        holds_served = 0;
  int        hold_left = 0;
  int        fail_count = 0;
  int        quiet_cycles = 0;

  double_hash_table_core #(
    .TABLE_SIZE   (TBL_SIZE),
    .SECOND_PRIME (SEC_PRIME)
  ) u_dut (
    .clk         (clk),
    .rst         (rst),
    .req_valid   (req_valid),
    .req_stall   (req_stall),
    .kind        (kind),
    .key         (key),
    .value       (value),
    .res_valid   (res_valid),
    .res_stall   (res_stall),
    .status      (status),
    .slot        (slot),
    .found_value (found_value)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Applies one request to the shadow table and returns the result it should give.
  function automatic res_t predict_table_result(req_t r);
    res_t o;
    int   pos;
    int   stride;
    int   hit;
    int   free_slot;
    bit   done;
    o.status = ST_NOT_FOUND;
    o.slot = '0;
    o.found_value = '0;
    hit = -1;
    free_slot = -1;
    done = 1'b0;
    if (r.kind == KIND_UNUSED) return o;
    pos = int'(r.key % TBL_SIZE);
    stride = int'((SEC_PRIME - r.key % SEC_PRIME) % TBL_SIZE);
    // Walk the probe path until a match, an empty slot, or a full lap.
    for (int n = 0; n < TBL_SIZE && !done; n++) begin
      if (shadow_mark[pos] == MARK_EMPTY) begin
        if (free_slot < 0) free_slot = pos;
        done = 1'b1;
      end else if (shadow_mark[pos] == MARK_USED) begin
        if (shadow_key[pos] == r.key) begin
          hit = pos;
          done = 1'b1;
        end
      end else if (free_slot < 0) begin
        free_slot = pos;
      end
      if (!done) pos = (pos + stride) % TBL_SIZE;
    end
    if (r.kind == KIND_INSERT) begin
      if (hit >= 0) begin
        shadow_val[hit] = r.value;
        o.status = ST_OVERWRITTEN;
        o.slot = hit[SLOT_W-1:0];
      end else if (free_slot >= 0) begin
        shadow_key[free_slot] = r.key;
        shadow_val[free_slot] = r.value;
        shadow_mark[free_slot] = MARK_USED;
        o.status = ST_INSERTED;
        o.slot = free_slot[SLOT_W-1:0];
      end else begin
        o.status = ST_FULL;
      end
    end else if (hit >= 0) begin
      o.slot = hit[SLOT_W-1:0];
      if (r.kind == KIND_REMOVE) begin
        shadow_mark[hit] = MARK_DELETED;
        o.status = ST_DELETED;
      end else begin
        o.found_value = shadow_val[hit];
        o.status = ST_FOUND;
      end
    end
    return o;
  endfunction

  // Offers one request, with random gaps ahead of it, and records its expected result.
  task automatic send_request(input req_t r, input bit typed, input res_t want);
    res_t predicted;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req_valid <= 1'b1;
    kind <= r.kind;
    key <= r.key;
    value <= r.value;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    predicted = predict_table_result(r);
    results_due.push_back(typed ? want : predicted);
  endtask

  task automatic wait_results_done();
    req_valid <= 1'b0;
    while (results_due.size() != 0) @(posedge clk);
  endtask

  task automatic set_idle_mode(input int mode);
    case (mode)
      0: begin
        send_idle_pct = 0;
        recv_stall_pct = 0;
      end
      1: begin
        send_idle_pct = 53;
        recv_stall_pct = 0;
      end
      2: begin
        send_idle_pct = 0;
        recv_stall_pct = 53;
      end
      default: begin
        send_idle_pct = 37;
        recv_stall_pct = 37;
      end
    endcase
  endtask

  task automatic add_row(input logic [KIND_W-1:0] k, input logic [KEY_W-1:0] ky,
                         input logic [VALUE_W-1:0] v, input bit typed,
                         input logic [STATUS_W-1:0] st, input logic [SLOT_W-1:0] sl,
                         input logic [VALUE_W-1:0] fv);
    dir_row_t row;
    row.req.kind = k;
    row.req.key = ky;
    row.req.value = v;
    row.typed = typed;
    row.want.status = st;
    row.want.slot = sl;
    row.want.found_value = fv;
    dir_rows.push_back(row);
  endtask

  // Builds a key set for one phase: small keys, keys near the top, keys that
  // collide on the first slots, and fully random ones.
  task automatic fill_key_pool(input int n);
    pool_n = n;
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(0, 3))
        0: key_pool[i] = $urandom_range(0, 200);
        1: key_pool[i] = $urandom();
        2: key_pool[i] = 32'hFFFF_FFFF - $urandom_range(0, 200);
        default: key_pool[i] = 31 * $urandom_range(0, 1000) + $urandom_range(0, 2);
      endcase
    end
  endtask

  function automatic req_t make_request(input int ins_pct);
    req_t r;
    int   pick;
    pick = $urandom_range(0, 99);
    if (pick < ins_pct) r.kind = KIND_INSERT;
    else if (pick < ins_pct + (100 - ins_pct) / 2) r.kind = KIND_SEARCH;
    else if (pick < 98) r.kind = KIND_REMOVE;
    else r.kind = KIND_UNUSED;
    r.key = ($urandom_range(0, 19) == 0) ? $urandom() : key_pool[$urandom_range(0, pool_n - 1)];
    r.value = $urandom();
    return r;
  endfunction

  // Compares one taken result with the oldest expectation.
  task automatic check_result();
    res_t want;
    if (results_due.size() == 0) begin
      fail_count++;
      if (fail_count <= 10)
        $display("Result with no request pending: status=%0d slot=%0d value=%0d",
                 status, slot, found_value);
    end else begin
      want = results_due.pop_front();
      if (status !== want.status || slot !== want.slot || found_value !== want.found_value) begin
        fail_count++;
        if (fail_count <= 10)
          $display("Mismatch: expected status=%0d slot=%0d value=%0d, got status=%0d slot=%0d value=%0d",
                   want.status, want.slot, want.found_value, status, slot, found_value);
      end
    end
  endtask

  // Result side: check taken results, then pick the stall for the next cycle.
  always @(posedge clk) begin
    if (!rst && res_valid && !res_stall) check_result();
    if (hold_left > 0) begin
      res_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (holds_served != holds_asked) begin
      holds_served <= holds_served + 1;
      hold_left <= LONG_HOLD;
      res_stall <= 1'b1;
    end else begin
      res_stall <= ($urandom_range(0, 99) < recv_stall_pct);
    end
  end

  // Count cycles in which neither channel moves.
  always @(posedge clk) begin
    if (rst || (req_valid && !req_stall) || (res_valid && !res_stall)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
  end

  initial begin
    wait (quiet_cycles >= WDOG_LIMIT);
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    res_t no_want;
    int   ins_pct;
    no_want.status = ST_NOT_FOUND;
    no_want.slot = '0;
    no_want.found_value = '0;

    // Directed table, starting from an empty table.
    add_row(KIND_SEARCH, 32'd0, 32'd0, 1, ST_NOT_FOUND, 5'd0, 32'd0);
    add_row(KIND_REMOVE, 32'hFFFF_FFFF, 32'd0, 1, ST_NOT_FOUND, 5'd0, 32'd0);
    add_row(KIND_UNUSED, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 1, ST_NOT_FOUND, 5'd0, 32'd0);
    add_row(KIND_INSERT, 32'd0, 32'h7FFF_FFFF, 1, ST_INSERTED, 5'd0, 32'd0);
    add_row(KIND_INSERT, 32'hFFFF_FFFF, 32'h8000_0000, 1, ST_INSERTED, 5'd3, 32'd0);
    add_row(KIND_SEARCH, 32'hFFFF_FFFF, 32'd0, 1, ST_FOUND, 5'd3, 32'h8000_0000);
    add_row(KIND_INSERT, 32'd0, 32'hFFFF_FFFF, 1, ST_OVERWRITTEN, 5'd0, 32'd0);
    add_row(KIND_SEARCH, 32'd0, 32'd0, 1, ST_FOUND, 5'd0, 32'hFFFF_FFFF);
    add_row(KIND_UNUSED, 32'd0, 32'd0, 1, ST_NOT_FOUND, 5'd0, 32'd0);
    // Collisions on slot zero and probe chains through a deleted slot.
    add_row(KIND_INSERT, 32'd31, 32'd5, 0, '0, '0, '0);
    add_row(KIND_REMOVE, 32'd0, 32'd0, 1, ST_DELETED, 5'd0, 32'd0);
    add_row(KIND_SEARCH, 32'd0, 32'd0, 0, '0, '0, '0);
    add_row(KIND_SEARCH, 32'd31, 32'd0, 0, '0, '0, '0);
    add_row(KIND_INSERT, 32'd62, 32'd12345, 0, '0, '0, '0);
    add_row(KIND_REMOVE, 32'd62, 32'd0, 0, '0, '0, '0);
    add_row(KIND_REMOVE, 32'd62, 32'd0, 0, '0, '0, '0);
    add_row(KIND_INSERT, 32'hAAAA_AAAA, 32'h5555_5555, 0, '0, '0, '0);
    add_row(KIND_INSERT, 32'h5555_5555, 32'hAAAA_AAAA, 0, '0, '0, '0);
    add_row(KIND_SEARCH, 32'hAAAA_AAAA, 32'd0, 0, '0, '0, '0);
    add_row(KIND_SEARCH, 32'h5555_5555, 32'd0, 0, '0, '0, '0);
    add_row(KIND_REMOVE, 32'hFFFF_FFFF, 32'd0, 1, ST_DELETED, 5'd3, 32'd0);
    add_row(KIND_SEARCH, 32'hFFFF_FFFF, 32'd0, 0, '0, '0, '0);

    for (int i = 0; i < TBL_SIZE; i++) shadow_mark[i] = MARK_EMPTY;

    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (dir_rows[i]) send_request(dir_rows[i].req, dir_rows[i].typed, dir_rows[i].want);
    wait_results_done();

    // Random phases; odd phases lean on inserts so the table runs full.
    for (int ph = 0; ph < PHASES; ph++) begin
      set_idle_mode(ph % 4);
      fill_key_pool((ph % 2) ? 40 + 3 * ph : 10 + 2 * ph);
      ins_pct = (ph % 2) ? 65 : 40;
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        // Long result hold while requests keep coming, so the input backs up.
        if (ph == 4 && i == 20) holds_asked++;
        // Sender pause until every pending result is back.
        if (ph == 6 && i == 60) wait_results_done();
        send_request(make_request(ins_pct), 1'b0, no_want);
      end
      wait_results_done();
    end

    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

endmodule

### sim.f
rtl/dht_pkg.sv
rtl/dht_ctrl.sv
rtl/dht_datapath.sv
rtl/double_hash_table_core.sv
rtl/dht_checker.sv
bench/tb_double_hash_table_core.sv
